// ===== hw/rtl/mer_pkg.sv =====
// Shared types and constants of the midpoint ellipse rasterizer.
`timescale 1ns / 1ps

package mer_pkg;

    localparam int PIXEL_BITS     = 13;
    localparam int DEC_BITS       = 64;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS_X = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS_Y = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTRE_X = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTRE_Y = 3'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT_MUL,
        ST_INIT_LOAD,
        ST_CHECK,
        ST_ADV_UPD,
        ST_SET_MUL,
        ST_SET_EVAL,
        ST_ENTER_MUL,
        ST_ENTER_LOAD
    } t_state;

    typedef struct packed {
        logic init_mul;
        logic init_load;
        logic adv_load;
        logic adv_update;
        logic settle_mul;
        logic settle_eval;
        logic enter_mul;
        logic enter_load;
    } t_dp_cmd;

    typedef struct packed {
        logic finished;
        logic need_enter;
    } t_dp_stat;

    typedef struct packed {
        logic load_pix;
        logic load_done;
    } t_emit_cmd;

endpackage

// ===== hw/rtl/mer_dp.sv =====
// Datapath: config registers, walk state, shared multipliers and decision update.
`timescale 1ns / 1ps

module mer_dp #(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 11
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [mer_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [mer_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  mer_pkg::t_dp_cmd                    i_cmd,
    output mer_pkg::t_dp_stat                   o_stat,
    output logic [RADIUS_BITS:0]                o_walk_x,
    output logic signed [RADIUS_BITS+1:0]       o_walk_y,
    output logic [COORD_BITS-1:0]               o_centre_x,
    output logic [COORD_BITS-1:0]               o_centre_y
);

    localparam int R   = RADIUS_BITS;
    localparam int XB  = R + 1;
    localparam int YB  = R + 2;
    localparam int XN  = R + 2;
    localparam int YN  = R + 3;
    localparam int SQ  = 2 * R;
    localparam int PA  = 3 * R + 2;
    localparam int PB  = 3 * R + 4;
    localparam int MB  = 3 * R;
    localparam int T2  = 2 * R + 4;
    localparam int UV  = 4 * R + 4;
    localparam int RRB = 4 * R;
    localparam int DB  = mer_pkg::DEC_BITS;

    logic [R-1:0]          r_radius_x;
    logic [R-1:0]          r_radius_y;
    logic [COORD_BITS-1:0] r_centre_x;
    logic [COORD_BITS-1:0] r_centre_y;
    logic [SQ-1:0]         r_rx2;
    logic [SQ-1:0]         r_ry2;

    logic [XB-1:0]         r_x;
    logic signed [YB-1:0]  r_y;
    logic [DB-1:0]         r_dec;
    logic                  r_region;
    logic                  r_fin;

    logic [PA-1:0]         r_pa;
    logic signed [PB-1:0]  r_pb;
    logic [XN-1:0]         r_xn;
    logic signed [YN-1:0]  r_yn;
    logic                  r_inc_x;
    logic                  r_dec_y;
    logic [MB-1:0]         r_m;
    logic [T2-1:0]         r_tx2;
    logic [T2-1:0]         r_ty2;
    logic [RRB-1:0]        r_rr;
    logic [UV-1:0]         r_u;
    logic [UV-1:0]         r_v;

    logic                  w_inc_x;
    logic                  w_dec_y;
    logic [XN-1:0]         w_x_op;
    logic signed [YN-1:0]  w_y_ext;
    logic signed [YN-1:0]  w_y_op;
    logic [PA-1:0]         w_pa;
    logic signed [SQ:0]    w_rx2_s;
    logic signed [PB-1:0]  w_pb;
    logic signed [PA:0]    w_pa_cmp;
    logic [XN-1:0]         w_tx;
    logic signed [YN-1:0]  w_ty;
    logic signed [2*YN-1:0] w_ty2_full;
    logic [DB-1:0]         w_pa8;
    logic [DB-1:0]         w_pb8;
    logic [DB-1:0]         w_bias;
    logic [DB-1:0]         n_dec_adv;
    logic [DB-1:0]         n_dec_init;
    logic [DB-1:0]         n_dec_enter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_x <= '0;
            r_radius_y <= '0;
            r_centre_x <= '0;
            r_centre_y <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mer_pkg::REG_RADIUS_X: r_radius_x <= i_cfg_data[R-1:0];
                mer_pkg::REG_RADIUS_Y: r_radius_y <= i_cfg_data[R-1:0];
                mer_pkg::REG_CENTRE_X: r_centre_x <= i_cfg_data[COORD_BITS-1:0];
                mer_pkg::REG_CENTRE_Y: r_centre_y <= i_cfg_data[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx2 <= r_radius_x * r_radius_x;
        r_ry2 <= r_radius_y * r_radius_y;
    end

    assign w_inc_x  = !r_region || r_dec[DB-1] || (r_dec == '0);
    assign w_dec_y  = r_region || !r_dec[DB-1];
    assign w_y_ext  = YN'(r_y);
    assign w_x_op   = (i_cmd.adv_load && w_inc_x) ? XN'(r_x) + XN'(1'b1) : XN'(r_x);
    assign w_y_op   = (i_cmd.adv_load && w_dec_y) ? w_y_ext - YN'(1) : w_y_ext;
    assign w_pa     = r_ry2 * w_x_op;
    assign w_rx2_s  = {1'b0, r_rx2};
    assign w_pb     = w_rx2_s * w_y_op;
    assign w_pa_cmp = {1'b0, r_pa};

    assign w_tx       = {r_x, 1'b1};
    assign w_ty       = w_y_ext - YN'(1);
    assign w_ty2_full = w_ty * w_ty;

    assign w_pa8  = DB'(r_pa) << 3;
    assign w_pb8  = DB'(r_pb) << 3;
    assign w_bias = r_region ? (DB'(r_rx2) << 2) : (DB'(r_ry2) << 2);

    assign n_dec_adv   = r_dec + (r_inc_x ? w_pa8 : '0) - (r_dec_y ? w_pb8 : '0) + w_bias;
    assign n_dec_init  = (DB'(r_ry2) << 2) - (DB'(r_m) << 2) + DB'(r_rx2);
    assign n_dec_enter = DB'(r_u) + (DB'(r_v) << 2) - (DB'(r_rr) << 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= '0;
            r_y      <= '0;
            r_dec    <= '0;
            r_region <= 1'b0;
            r_fin    <= 1'b1;
        end else begin
            if (i_cmd.init_load) begin
                r_x      <= '0;
                r_y      <= YB'(r_radius_y);
                r_dec    <= n_dec_init;
                r_region <= 1'b0;
                r_fin    <= 1'b0;
            end
            if (i_cmd.adv_update) begin
                r_x   <= r_xn[XB-1:0];
                r_y   <= r_yn[YB-1:0];
                r_dec <= n_dec_adv;
            end
            if (i_cmd.settle_eval && !r_fin && r_region) begin
                r_fin <= r_y[YB-1];
            end
            if (i_cmd.enter_load) begin
                r_dec    <= n_dec_enter;
                r_region <= 1'b1;
                r_fin    <= r_y[YB-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.adv_load || i_cmd.settle_mul) begin
            r_pa <= w_pa;
            r_pb <= w_pb;
        end
        if (i_cmd.adv_load) begin
            r_xn    <= w_x_op;
            r_yn    <= w_y_op;
            r_inc_x <= w_inc_x;
            r_dec_y <= w_dec_y;
        end
        if (i_cmd.init_mul) begin
            r_m <= r_rx2 * r_radius_y;
        end
        if (i_cmd.settle_eval) begin
            r_tx2 <= w_tx * w_tx;
            r_ty2 <= w_ty2_full[T2-1:0];
            r_rr  <= r_rx2 * r_ry2;
        end
        if (i_cmd.enter_mul) begin
            r_u <= r_ry2 * r_tx2;
            r_v <= r_rx2 * r_ty2;
        end
    end

    assign o_stat.finished   = r_fin;
    assign o_stat.need_enter = !r_fin && !r_region && !(w_pa_cmp < r_pb);

    assign o_walk_x   = r_x;
    assign o_walk_y   = r_y;
    assign o_centre_x = r_centre_x;
    assign o_centre_y = r_centre_y;

endmodule

// ===== hw/rtl/mer_ctrl.sv =====
// Controller state machine sequencing restart, advance and region settle.
`timescale 1ns / 1ps

module mer_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step_valid,
    input  logic               i_restart,
    output logic               o_step_ready,
    input  mer_pkg::t_dp_stat  i_stat,
    input  logic               i_emit_busy,
    output mer_pkg::t_dp_cmd   o_cmd,
    output mer_pkg::t_emit_cmd o_emit
);

    mer_pkg::t_state r_state;
    mer_pkg::t_state n_state;
    logic            r_init;
    logic            w_accept;

    assign w_accept = i_step_valid && (r_state == mer_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mer_pkg::ST_IDLE;
            r_init  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_init <= i_restart;
            end else if (r_state == mer_pkg::ST_CHECK) begin
                r_init <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mer_pkg::ST_IDLE: begin
                if (i_step_valid) begin
                    n_state = i_restart ? mer_pkg::ST_INIT_MUL : mer_pkg::ST_CHECK;
                end
            end
            mer_pkg::ST_INIT_MUL:  n_state = mer_pkg::ST_INIT_LOAD;
            mer_pkg::ST_INIT_LOAD: n_state = mer_pkg::ST_SET_MUL;
            mer_pkg::ST_CHECK: begin
                if (!i_emit_busy) begin
                    n_state = i_stat.finished ? mer_pkg::ST_IDLE : mer_pkg::ST_ADV_UPD;
                end
            end
            mer_pkg::ST_ADV_UPD: n_state = mer_pkg::ST_SET_MUL;
            mer_pkg::ST_SET_MUL: n_state = mer_pkg::ST_SET_EVAL;
            mer_pkg::ST_SET_EVAL: begin
                if (i_stat.need_enter) begin
                    n_state = mer_pkg::ST_ENTER_MUL;
                end else begin
                    n_state = r_init ? mer_pkg::ST_CHECK : mer_pkg::ST_IDLE;
                end
            end
            mer_pkg::ST_ENTER_MUL:  n_state = mer_pkg::ST_ENTER_LOAD;
            mer_pkg::ST_ENTER_LOAD: n_state = r_init ? mer_pkg::ST_CHECK : mer_pkg::ST_IDLE;
            default:                n_state = mer_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_emit       = '0;
        o_step_ready = 1'b0;
        unique case (r_state)
            mer_pkg::ST_IDLE:       o_step_ready = 1'b1;
            mer_pkg::ST_INIT_MUL:   o_cmd.init_mul = 1'b1;
            mer_pkg::ST_INIT_LOAD:  o_cmd.init_load = 1'b1;
            mer_pkg::ST_CHECK: begin
                if (!i_emit_busy) begin
                    if (i_stat.finished) begin
                        o_emit.load_done = 1'b1;
                    end else begin
                        o_emit.load_pix = 1'b1;
                        o_cmd.adv_load  = 1'b1;
                    end
                end
            end
            mer_pkg::ST_ADV_UPD:    o_cmd.adv_update = 1'b1;
            mer_pkg::ST_SET_MUL:    o_cmd.settle_mul = 1'b1;
            mer_pkg::ST_SET_EVAL:   o_cmd.settle_eval = 1'b1;
            mer_pkg::ST_ENTER_MUL:  o_cmd.enter_mul = 1'b1;
            mer_pkg::ST_ENTER_LOAD: o_cmd.enter_load = 1'b1;
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/mer_emit.sv =====
// Output stage: registers the four symmetric pixels or the done result.
`timescale 1ns / 1ps

module mer_emit #(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 11
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mer_pkg::t_emit_cmd                  i_cmd,
    input  logic [RADIUS_BITS:0]                i_walk_x,
    input  logic signed [RADIUS_BITS+1:0]       i_walk_y,
    input  logic [COORD_BITS-1:0]               i_centre_x,
    input  logic [COORD_BITS-1:0]               i_centre_y,
    output logic                                o_busy,
    output logic                                o_pix_valid,
    input  logic                                i_pix_ready,
    output logic [mer_pkg::PIXEL_BITS-1:0]      o_pixel_x,
    output logic [mer_pkg::PIXEL_BITS-1:0]      o_pixel_y,
    output logic                                o_last,
    output logic                                o_done_res
);

    localparam int PB       = mer_pkg::PIXEL_BITS;
    localparam int W1       = (COORD_BITS > RADIUS_BITS + 2) ? COORD_BITS : RADIUS_BITS + 2;
    localparam int SUM_BITS = (W1 + 2 > PB) ? W1 + 2 : PB;

    logic                          r_busy;
    logic                          r_done;
    logic [1:0]                    r_k;
    logic [RADIUS_BITS:0]          r_sx;
    logic signed [RADIUS_BITS+1:0] r_sy;
    logic [PB-1:0]                 r_px;
    logic [PB-1:0]                 r_py;
    logic                          w_take;
    logic                          w_final;

    function automatic logic [2*PB-1:0] pix(
        input logic [RADIUS_BITS:0]          x,
        input logic signed [RADIUS_BITS+1:0] y,
        input logic [COORD_BITS-1:0]         cx,
        input logic [COORD_BITS-1:0]         cy,
        input logic [1:0]                    k
    );
        logic signed [SUM_BITS-1:0] sx;
        logic signed [SUM_BITS-1:0] sy;
        logic signed [SUM_BITS-1:0] scx;
        logic signed [SUM_BITS-1:0] scy;
        logic signed [SUM_BITS-1:0] px;
        logic signed [SUM_BITS-1:0] py;
        sx  = SUM_BITS'(x);
        sy  = SUM_BITS'(y);
        scx = SUM_BITS'(cx);
        scy = SUM_BITS'(cy);
        px  = k[0] ? scx - sx : scx + sx;
        py  = k[1] ? scy - sy : scy + sy;
        return {px[PB-1:0], py[PB-1:0]};
    endfunction

    assign w_take  = r_busy && i_pix_ready;
    assign w_final = r_done || (r_k == 2'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else if (i_cmd.load_pix) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_k    <= '0;
        end else if (i_cmd.load_done) begin
            r_busy <= 1'b1;
            r_done <= 1'b1;
            r_k    <= '0;
        end else if (w_take) begin
            if (w_final) begin
                r_busy <= 1'b0;
            end else begin
                r_k <= r_k + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pix) begin
            r_sx         <= i_walk_x;
            r_sy         <= i_walk_y;
            {r_px, r_py} <= pix(i_walk_x, i_walk_y, i_centre_x, i_centre_y, 2'd0);
        end else if (i_cmd.load_done) begin
            r_px <= '0;
            r_py <= '0;
        end else if (w_take && !w_final) begin
            {r_px, r_py} <= pix(r_sx, r_sy, i_centre_x, i_centre_y, r_k + 2'd1);
        end
    end

    assign o_busy      = r_busy;
    assign o_pix_valid = r_busy;
    assign o_pixel_x   = r_px;
    assign o_pixel_y   = r_py;
    assign o_last      = w_final;
    assign o_done_res  = r_done;

endmodule

// ===== hw/rtl/midpoint_ellipse_rasterizer_unit.sv =====
// Plain step: passes through the sequencer states idle/accept, check, update, settle multiply
// and settle compare, plus enter multiply and enter load when the walk enters region two; restart
// first runs init multiply, init load and the settle states (and the enter states when the walk
// starts in region two). Four pixels leave one per cycle while the output is ready, as the shared
// multiplier pair advances the walk; a new step is taken while they drain, its check waits for them.
// Synchronous active-low reset clears config, walk state (walk marked finished), output stage.
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_unit #(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 11
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_step_valid,
    output logic                               o_step_ready,
    input  logic                               i_restart,
    output logic                               o_pix_valid,
    input  logic                               i_pix_ready,
    output logic [mer_pkg::PIXEL_BITS-1:0]     o_pixel_x,
    output logic [mer_pkg::PIXEL_BITS-1:0]     o_pixel_y,
    output logic                               o_last,
    output logic                               o_done_res,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mer_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [mer_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    mer_pkg::t_dp_cmd              w_cmd;
    mer_pkg::t_dp_stat             w_stat;
    mer_pkg::t_emit_cmd            w_emit_cmd;
    logic                          w_emit_busy;
    logic [RADIUS_BITS:0]          w_walk_x;
    logic signed [RADIUS_BITS+1:0] w_walk_y;
    logic [COORD_BITS-1:0]         w_centre_x;
    logic [COORD_BITS-1:0]         w_centre_y;

    assign o_cfg_ready = 1'b1;

    mer_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step_valid (i_step_valid),
        .i_restart    (i_restart),
        .o_step_ready (o_step_ready),
        .i_stat       (w_stat),
        .i_emit_busy  (w_emit_busy),
        .o_cmd        (w_cmd),
        .o_emit       (w_emit_cmd)
    );

    mer_dp #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_walk_x    (w_walk_x),
        .o_walk_y    (w_walk_y),
        .o_centre_x  (w_centre_x),
        .o_centre_y  (w_centre_y)
    );

    mer_emit #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_emit_cmd),
        .i_walk_x    (w_walk_x),
        .i_walk_y    (w_walk_y),
        .i_centre_x  (w_centre_x),
        .i_centre_y  (w_centre_y),
        .o_busy      (w_emit_busy),
        .o_pix_valid (o_pix_valid),
        .i_pix_ready (i_pix_ready),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_last      (o_last),
        .o_done_res  (o_done_res)
    );

endmodule

// ===== hw/rtl/mer_checker.sv =====
// Port-level checker of the midpoint ellipse rasterizer, bound to the top level.
`timescale 1ns / 1ps

module mer_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_step_valid,
    input logic                           o_step_ready,
    input logic                           o_pix_valid,
    input logic                           i_pix_ready,
    input logic [mer_pkg::PIXEL_BITS-1:0] o_pixel_x,
    input logic [mer_pkg::PIXEL_BITS-1:0] o_pixel_y,
    input logic                           o_last,
    input logic                           o_done_res
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix_valid && !i_pix_ready) |=> (o_pix_valid && $stable(o_pixel_x) &&
        $stable(o_pixel_y) && $stable(o_last) && $stable(o_done_res)))
        else $error("output transaction changed while stalled");

    a_done_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix_valid && o_done_res) |-> (o_last && o_pixel_x == '0 && o_pixel_y == '0))
        else $error("done result must be a lone zero result marked last");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix_valid && i_pix_ready && !o_last) |=> (o_pix_valid && !o_done_res))
        else $error("pixel run broken before its last transaction");

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step_valid && o_step_ready) |=> !o_step_ready)
        else $error("second step taken before the first was sequenced");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pix_valid)
        else $error("output valid right after reset");

endmodule

bind midpoint_ellipse_rasterizer_unit mer_checker u_mer_checker (.*);

// ===== verif/tb_midpoint_ellipse_rasterizer_unit.sv =====
// Testbench for the midpoint ellipse rasterizer: directed and random walks vs a local predictor.
`timescale 1ns / 1ps

module tb_midpoint_ellipse_rasterizer_unit;

    localparam int PIXEL_BITS     = mer_pkg::PIXEL_BITS;
    localparam int CFG_INDEX_BITS = mer_pkg::CFG_INDEX_BITS;
    localparam int CFG_DATA_BITS  = mer_pkg::CFG_DATA_BITS;

    localparam int RADIUS_BITS   = 10;
    localparam int COORD_BITS    = 11;
    localparam int RANDOM_ITEMS  = 410;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] x;
        logic [PIXEL_BITS-1:0] y;
        logic                  last;
        logic                  done;
    } t_pixel;

    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      i_step_valid = 1'b0;
    logic                      i_restart    = 1'b0;
    logic                      i_pix_ready  = 1'b0;
    logic                      i_cfg_valid  = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index  = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data   = '0;
    logic                      o_step_ready;
    logic                      o_pix_valid;
    logic [PIXEL_BITS-1:0]     o_pixel_x;
    logic [PIXEL_BITS-1:0]     o_pixel_y;
    logic                      o_last;
    logic                      o_done_res;
    logic                      o_cfg_ready;

    midpoint_ellipse_rasterizer_unit #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step_valid (i_step_valid),
        .o_step_ready (o_step_ready),
        .i_restart    (i_restart),
        .o_pix_valid  (o_pix_valid),
        .i_pix_ready  (i_pix_ready),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_last       (o_last),
        .o_done_res   (o_done_res),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predictor state
    logic [RADIUS_BITS-1:0] cfg_radius_x    = '0;
    logic [RADIUS_BITS-1:0] cfg_radius_y    = '0;
    logic [COORD_BITS-1:0]  cfg_centre_x    = '0;
    logic [COORD_BITS-1:0]  cfg_centre_y    = '0;
    logic [RADIUS_BITS:0]   walk_x          = '0;
    logic [RADIUS_BITS+1:0] walk_y          = '0;
    logic [63:0]            walk_decision   = '0;
    logic                   walk_region_two = 1'b0;
    logic                   walk_finished   = 1'b1;

    t_pixel expected_pixels[$];

    int  error_count    = 0;
    int  steps_sent     = 0;
    int  pixels_checked = 0;
    int  done_results   = 0;
    int  cfg_writes     = 0;
    int  cycle_count    = 0;
    int  burst_left     = 0;
    bit  gaps_on        = 1'b1;
    bit  hold_request   = 1'b0;
    bit  hold_done      = 1'b0;
    int  hold_left      = 0;
    int  stall_mode     = 0;
    int  stall_left     = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic apply_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] data);
        case (index)
            mer_pkg::REG_RADIUS_X: cfg_radius_x = data[RADIUS_BITS-1:0];
            mer_pkg::REG_RADIUS_Y: cfg_radius_y = data[RADIUS_BITS-1:0];
            mer_pkg::REG_CENTRE_X: cfg_centre_x = data[COORD_BITS-1:0];
            mer_pkg::REG_CENTRE_Y: cfg_centre_y = data[COORD_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic walk_settle();
        logic [63:0] rx2, ry2, xw, yw, tx, ty;
        rx2 = 64'(cfg_radius_x) * 64'(cfg_radius_x);
        ry2 = 64'(cfg_radius_y) * 64'(cfg_radius_y);
        xw  = 64'(walk_x);
        yw  = {{(64-RADIUS_BITS-2){walk_y[RADIUS_BITS+1]}}, walk_y};
        if (walk_finished) return;
        if (!walk_region_two) begin
            if ($signed(ry2 * xw) < $signed(rx2 * yw)) return;
            tx = 64'd2 * xw + 64'd1;
            ty = yw - 64'd1;
            walk_decision = ry2 * tx * tx + 64'd4 * rx2 * ty * ty - 64'd4 * rx2 * ry2;
            walk_region_two = 1'b1;
        end
        if (yw[63]) walk_finished = 1'b1;
    endtask

    task automatic walk_advance();
        logic [63:0] rx2, ry2, xw, yw;
        rx2 = 64'(cfg_radius_x) * 64'(cfg_radius_x);
        ry2 = 64'(cfg_radius_y) * 64'(cfg_radius_y);
        xw  = 64'(walk_x);
        yw  = {{(64-RADIUS_BITS-2){walk_y[RADIUS_BITS+1]}}, walk_y};
        if (!walk_region_two) begin
            xw = xw + 64'd1;
            if (walk_decision[63]) begin
                walk_decision += 64'd8 * ry2 * xw + 64'd4 * ry2;
            end else begin
                yw = yw - 64'd1;
                walk_decision += 64'd8 * ry2 * xw - 64'd8 * rx2 * yw + 64'd4 * ry2;
            end
        end else begin
            yw = yw - 64'd1;
            if (!walk_decision[63] && walk_decision != 64'd0) begin
                walk_decision += 64'd4 * rx2 - 64'd8 * rx2 * yw;
            end else begin
                xw = xw + 64'd1;
                walk_decision += 64'd8 * ry2 * xw - 64'd8 * rx2 * yw + 64'd4 * rx2;
            end
        end
        walk_x = xw[RADIUS_BITS:0];
        walk_y = yw[RADIUS_BITS+1:0];
        walk_settle();
    endtask

    task automatic predict_step(input logic restart);
        logic [63:0]           rx2, ry2;
        logic [PIXEL_BITS-1:0] cx, cy, dx, dy;
        t_pixel                pix;
        if (restart) begin
            rx2 = 64'(cfg_radius_x) * 64'(cfg_radius_x);
            ry2 = 64'(cfg_radius_y) * 64'(cfg_radius_y);
            walk_x          = '0;
            walk_y          = (RADIUS_BITS+2)'(cfg_radius_y);
            walk_decision   = 64'd4 * ry2 - 64'd4 * rx2 * 64'(cfg_radius_y) + rx2;
            walk_region_two = 1'b0;
            walk_finished   = 1'b0;
            walk_settle();
        end
        if (walk_finished) begin
            expected_pixels.push_back('{x: '0, y: '0, last: 1'b1, done: 1'b1});
            done_results++;
            return;
        end
        cx = PIXEL_BITS'(cfg_centre_x);
        cy = PIXEL_BITS'(cfg_centre_y);
        dx = PIXEL_BITS'(walk_x);
        dy = {walk_y[RADIUS_BITS+1], walk_y};
        for (int k = 0; k < 4; k++) begin
            pix.x    = k[0] ? cx - dx : cx + dx;
            pix.y    = k[1] ? cy - dy : cy + dy;
            pix.last = (k == 3);
            pix.done = 1'b0;
            expected_pixels.push_back(pix);
        end
        walk_advance();
    endtask

    task automatic send_step(input logic restart);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on) begin
                gap = $urandom_range(1, 6);
                i_step_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_step_valid <= 1'b1;
        i_restart    <= restart;
        do @(posedge i_clk); while (!o_step_ready);
        predict_step(restart);
        steps_sent++;
    endtask

    task automatic wait_idle();
        i_step_valid <= 1'b0;
        burst_left = 0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(index, data);
        cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_ellipse(input int rx, input int ry, input int cx, input int cy);
        wait_idle();
        write_register(mer_pkg::REG_RADIUS_X, CFG_DATA_BITS'(rx));
        write_register(mer_pkg::REG_RADIUS_Y, CFG_DATA_BITS'(ry));
        write_register(mer_pkg::REG_CENTRE_X, CFG_DATA_BITS'(cx));
        write_register(mer_pkg::REG_CENTRE_Y, CFG_DATA_BITS'(cy));
    endtask

    task automatic finish_walk(input int cap);
        int n;
        n = 0;
        while (!walk_finished && n < cap) begin
            send_step(1'b0);
            n++;
        end
        send_step(1'b0);
    endtask

    task automatic test_no_walk();
        send_step(1'b0);
        send_step(1'b0);
    endtask

    task automatic test_zero_radius();
        set_ellipse(0, 0, 100, 200);
        send_step(1'b1);
        finish_walk(4);
        set_ellipse(3, 0, 1024, 5);
        send_step(1'b1);
        finish_walk(4);
        set_ellipse(0, 3, 7, 1024);
        send_step(1'b1);
        finish_walk(8);
    endtask

    task automatic test_extremes();
        set_ellipse(1023, 1023, 2047, 2047);
        send_step(1'b1);
        send_step(1'b0);
        set_ellipse(1023, 1023, 0, 0);
        send_step(1'b1);
    endtask

    task automatic test_register_masking();
        wait_idle();
        write_register(mer_pkg::REG_RADIUS_X, 16'hFC07);
        write_register(mer_pkg::REG_RADIUS_Y, 16'h0405);
        write_register(mer_pkg::REG_CENTRE_X, 16'hFDDC);
        write_register(mer_pkg::REG_CENTRE_Y, 16'h0FFF);
        for (int idx = int'(mer_pkg::REG_CENTRE_Y) + 1; idx < (1 << CFG_INDEX_BITS); idx++)
            write_register(CFG_INDEX_BITS'(idx), 16'hFFFF);
        send_step(1'b1);
        send_step(1'b0);
    endtask

    task automatic test_register_change_mid_walk();
        set_ellipse(8, 6, 300, 400);
        send_step(1'b1);
        send_step(1'b0);
        wait_idle();
        write_register(mer_pkg::REG_RADIUS_X, 16'd12);
        write_register(mer_pkg::REG_CENTRE_Y, 16'd10);
        send_step(1'b0);
        send_step(1'b0);
    endtask

    task automatic test_output_backpressure();
        set_ellipse(40, 30, 900, 700);
        gaps_on = 1'b0;
        hold_request = 1'b1;
        send_step(1'b1);
        repeat (14) send_step(1'b0);
        wait_idle();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_walks();
        int          target, cap, n;
        bit          big;
        logic [9:0]  rx, ry;
        logic [10:0] cx, cy;
        target = steps_sent + RANDOM_ITEMS;
        while (steps_sent < target) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            big = 1'b0;
            case ($urandom_range(0, 19))
                0: begin
                    rx = 10'd1023;
                    ry = 10'($urandom);
                    big = 1'b1;
                end
                1: begin
                    rx = 10'($urandom);
                    ry = 10'd1023;
                    big = 1'b1;
                end
                2, 3: begin
                    rx = 10'($urandom_range(0, 63));
                    ry = 10'($urandom_range(0, 63));
                end
                default: begin
                    rx = 10'($urandom_range(0, 20));
                    ry = 10'($urandom_range(0, 20));
                end
            endcase
            case ($urandom_range(0, 5))
                0: cx = '0;
                1: cx = '1;
                default: cx = 11'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0: cy = '0;
                1: cy = '1;
                default: cy = 11'($urandom);
            endcase
            wait_idle();
            write_register(mer_pkg::REG_RADIUS_X, {6'($urandom), rx});
            write_register(mer_pkg::REG_RADIUS_Y, {6'($urandom), ry});
            if ($urandom_range(0, 7) != 0)
                write_register(mer_pkg::REG_CENTRE_X, {5'($urandom), cx});
            if ($urandom_range(0, 7) != 0)
                write_register(mer_pkg::REG_CENTRE_Y, {5'($urandom), cy});
            if ($urandom_range(0, 7) == 0)
                write_register(CFG_INDEX_BITS'($urandom_range(int'(mer_pkg::REG_CENTRE_Y) + 1,
                               (1 << CFG_INDEX_BITS) - 1)), 16'($urandom));
            send_step($urandom_range(0, 7) != 0);
            cap = big ? $urandom_range(4, 16) : 200;
            n = 0;
            while (!walk_finished && n < cap) begin
                if ($urandom_range(0, 29) == 0) begin
                    wait_idle();
                    if ($urandom_range(0, 1) == 0)
                        write_register(($urandom_range(0, 1) == 0) ? mer_pkg::REG_RADIUS_X
                                                                    : mer_pkg::REG_RADIUS_Y,
                                       16'($urandom_range(1, 40)));
                    else
                        write_register(($urandom_range(0, 1) == 0) ? mer_pkg::REG_CENTRE_X
                                                                    : mer_pkg::REG_CENTRE_Y,
                                       16'($urandom));
                end
                send_step($urandom_range(0, 39) == 0);
                n++;
            end
            repeat ($urandom_range(0, 2)) send_step(1'b0);
        end
    endtask

    // Output side: stall pattern plus one long hold-off
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(16, 96);
        end else begin
            stall_left <= stall_left - 1;
        end
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_pix_ready <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_pix_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0:       i_pix_ready <= 1'b1;
                1:       i_pix_ready <= ($urandom_range(0, 2) != 0);
                default: i_pix_ready <= (stall_left[1:0] == 2'd0);
            endcase
        end
    end

    always @(posedge i_clk) begin : pixel_check
        t_pixel got, want;
        if (i_rst_n && o_pix_valid && i_pix_ready) begin
            got = '{x: o_pixel_x, y: o_pixel_y, last: o_last, done: o_done_res};
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected result x=%0d y=%0d last=%b done=%b",
                                          $signed(got.x), $signed(got.y), got.last, got.done));
            end else begin
                want = expected_pixels.pop_front();
                if (got.x !== want.x)
                    report_mismatch($sformatf("pixel_x got %0d expected %0d",
                                              $signed(got.x), $signed(want.x)));
                if (got.y !== want.y)
                    report_mismatch($sformatf("pixel_y got %0d expected %0d",
                                              $signed(got.y), $signed(want.y)));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last got %b expected %b", got.last, want.last));
                if (got.done !== want.done)
                    report_mismatch($sformatf("done_res got %b expected %b",
                                              got.done, want.done));
                pixels_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_pixels.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_no_walk();
        test_zero_radius();
        test_extremes();
        test_register_masking();
        test_register_change_mid_walk();
        test_output_backpressure();
        test_random_walks();
        wait_idle();
        $display("Covered %0d steps, %0d results checked, %0d register writes,",
                 steps_sent, pixels_checked, cfg_writes);
        $display("including %0d finished-walk results and one long output hold-off.",
                 done_results);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mer_pkg.sv
hw/rtl/mer_dp.sv
hw/rtl/mer_ctrl.sv
hw/rtl/mer_emit.sv
hw/rtl/midpoint_ellipse_rasterizer_unit.sv
hw/rtl/mer_checker.sv
verif/tb_midpoint_ellipse_rasterizer_unit.sv
